### hw/rtl/assert_macros.svh
// ------------------------------------------------------------------------
// assertion macros
// clocked property checks used by matrix_determinant_engine
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check held off while reset is high
`define MDE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds during reset
`define MDE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/mde_pkg.sv
// ------------------------------------------------------------------------
// mde_pkg
// types, constants and tables of the matrix determinant engine
// ------------------------------------------------------------------------
package mde_pkg;

   localparam int MAX_SIZE_DEFAULT = 4;
   localparam int ELEM_W           = 12;
   localparam int DET_W            = 50;
   localparam int SIZE_W           = 3;
   localparam int COUNT_W          = 5;
   localparam int PROD_W           = 48;
   localparam int PERM_W           = 5;
   localparam int STORE_ADDR_W     = 4;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;
   localparam int PERM_COUNT       = 24;

   localparam logic REG_ROW_COUNT    = 1'b0;
   localparam logic REG_COLUMN_COUNT = 1'b1;

   localparam logic STATUS_OK         = 1'b0;
   localparam logic STATUS_NOT_SQUARE = 1'b1;

   typedef enum logic [1:0] {
      S_LOAD,
      S_CALC,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                     en;
      logic [STORE_ADDR_W-1:0]  addr;
      logic signed [ELEM_W-1:0] data;
   } store_write_type;

   typedef struct packed {
      logic              start;
      logic [SIZE_W-1:0] size;
   } calc_ctrl_type;

   // column per row, two bits each, row 0 in the low bits;
   // the first n! entries are the permutations of the first n columns
   localparam logic [7:0] PERM_TABLE [PERM_COUNT] = '{
      8'hE4, 8'hE1, 8'hD8, 8'hC9, 8'hD2, 8'hC6,
      8'hB4, 8'h78, 8'h9C, 8'h6C, 8'hB1, 8'h39,
      8'h8D, 8'h2D, 8'h72, 8'h36, 8'h4E, 8'h1E,
      8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
   };

   // odd permutations
   localparam logic [PERM_COUNT-1:0] PERM_NEG = 24'h665A66;

   function automatic logic [PERM_W-1:0] perm_count(input logic [SIZE_W-1:0] n);
      logic [PERM_W-1:0] c;
      case (n)
         3'd1:    c = 5'd1;
         3'd2:    c = 5'd2;
         3'd3:    c = 5'd6;
         default: c = 5'd24;
      endcase
      return c;
   endfunction

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
      logic [SIZE_W-1:0] c;
      if (v == '0) begin
         c = SIZE_W'(1);
      end else if (v > max_v) begin
         c = max_v;
      end else begin
         c = v;
      end
      return c;
   endfunction

endpackage

### hw/rtl/mde_interfaces.sv
// ------------------------------------------------------------------------
// mde channel interfaces
// valid/ready channels for matrix elements and determinant results
// ------------------------------------------------------------------------
interface mde_req_if;
   import mde_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [ELEM_W-1:0] element_value;

   modport source (output valid, output element_value, input ready);
   modport sink (input valid, input element_value, output ready);
endinterface

interface mde_rsp_if;
   import mde_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [DET_W-1:0] determinant;
   logic                    status;

   modport source (output valid, output determinant, output status, input ready);
   modport sink (input valid, input determinant, input status, output ready);
endinterface

### hw/rtl/mde_core.sv
// ------------------------------------------------------------------------
// mde_core
// element memory and permutation sum sequencer for the determinant
// ------------------------------------------------------------------------
module mde_core #(
   parameter int MAX_SIZE = mde_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mde_pkg::store_write_type         wr,
   input  mde_pkg::calc_ctrl_type           ctrl,
   output logic                             done,
   output logic signed [mde_pkg::DET_W-1:0] det
);
   import mde_pkg::*;

   localparam int DEPTH = MAX_SIZE * MAX_SIZE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [ELEM_W-1:0] mem [DEPTH];
   logic signed [ELEM_W-1:0] rd_data_ff;
   logic [AW-1:0]            rd_addr;

   logic              active_ff, active_in;
   logic [PERM_W-1:0] perm_ff, perm_in;
   logic [1:0]        row_ff, row_in;
   logic [SIZE_W-1:0] size_ff;
   logic [PERM_W-1:0] count;
   logic              row_last;
   logic              perm_final;
   logic [1:0]        col;
   logic [4:0]        addr_full;

   logic v1_ff, first1_ff, last1_ff, neg1_ff, final1_ff;
   logic v2_ff, neg2_ff, final2_ff;
   logic done_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [DET_W-1:0]  acc_ff, acc_in;

   assign count      = perm_count(size_ff);
   assign row_last   = ({1'b0, row_ff} == size_ff - SIZE_W'(1));
   assign perm_final = (perm_ff == count - PERM_W'(1));
   assign col        = PERM_TABLE[perm_ff][2*row_ff +: 2];
   assign addr_full  = 5'(row_ff) * 5'(size_ff) + 5'(col);
   assign rd_addr    = addr_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      active_in = active_ff;
      perm_in   = perm_ff;
      row_in    = row_ff;
      if (ctrl.start) begin
         active_in = 1'b1;
         perm_in   = '0;
         row_in    = '0;
      end else if (active_ff) begin
         if (row_last) begin
            row_in = '0;
            if (perm_final) begin
               active_in = 1'b0;
            end else begin
               perm_in = perm_ff + PERM_W'(1);
            end
         end else begin
            row_in = row_ff + 2'd1;
         end
      end
   end

   always_comb begin
      prod_in = prod_ff;
      if (v1_ff) begin
         if (first1_ff) begin
            prod_in = PROD_W'(rd_data_ff);
         end else begin
            prod_in = PROD_W'(prod_ff * PROD_W'(rd_data_ff));
         end
      end
      acc_in = acc_ff;
      if (ctrl.start) begin
         acc_in = '0;
      end else if (v2_ff) begin
         if (neg2_ff) begin
            acc_in = acc_ff - DET_W'(prod_ff);
         end else begin
            acc_in = acc_ff + DET_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         v1_ff     <= active_ff & ~ctrl.start;
         v2_ff     <= v1_ff & last1_ff;
         done_ff   <= v2_ff & final2_ff;
      end
   end

   always_ff @(posedge clock) begin
      perm_ff   <= perm_in;
      row_ff    <= row_in;
      if (ctrl.start) begin
         size_ff <= ctrl.size;
      end
      first1_ff <= (row_ff == 2'd0);
      last1_ff  <= row_last;
      neg1_ff   <= PERM_NEG[perm_ff];
      final1_ff <= row_last & perm_final;
      neg2_ff   <= neg1_ff;
      final2_ff <= final1_ff;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
   end

   assign done = done_ff;
   assign det  = acc_ff;

endmodule

### hw/rtl/matrix_determinant_engine.sv
// loading: each accepted item writes one element; an n-by-n matrix then takes n * n!
// memory reads (96 for 4x4) through the single read port, one element read per cycle,
// and the sum passes the product and accumulator registers to the result register;
// no new elements are taken until the result is registered; non-square sizes skip the reads
// reset: synchronous, active high; sizes go to MAX_SIZE, load count and rsp valid clear
// ------------------------------------------------------------------------
// matrix_determinant_engine
// loads a matrix element by element and returns its exact determinant
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix_determinant_engine #(
   parameter int MAX_SIZE = mde_pkg::MAX_SIZE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   mde_req_if.sink                             req_item,
   mde_rsp_if.source                           rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mde_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [mde_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [mde_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import mde_pkg::*;

   localparam logic [SIZE_W-1:0] MAX_SZ = SIZE_W'(MAX_SIZE);

   state_type state_ff, state_in;
   logic [SIZE_W-1:0]  row_count_ff, column_count_ff;
   logic [COUNT_W-1:0] load_count_ff, load_count_in;
   logic               status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [DET_W-1:0] rsp_det_ff, rsp_det_in;
   logic               rsp_status_ff, rsp_status_in;

   logic [SIZE_W-1:0]  rows, cols;
   logic [COUNT_W-1:0] total;
   logic               req_fire, cfg_wr, is_last, slot_free;
   store_write_type    wr;
   calc_ctrl_type      ctrl;
   logic               core_done;
   logic signed [DET_W-1:0] core_det;

   assign rows      = clamp_size(row_count_ff, MAX_SZ);
   assign cols      = clamp_size(column_count_ff, MAX_SZ);
   assign total     = COUNT_W'(rows) * COUNT_W'(cols);
   assign req_fire  = req_item.valid & req_item.ready;
   assign cfg_wr    = psel & penable & pwrite;
   assign is_last   = (load_count_ff + COUNT_W'(1) == total);
   assign slot_free = ~rsp_valid_ff | rsp_item.ready;

   assign wr.en   = req_fire;
   assign wr.addr = load_count_ff[STORE_ADDR_W-1:0];
   assign wr.data = req_item.element_value;

   mde_core #(
      .MAX_SIZE(MAX_SIZE)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .wr(wr),
      .ctrl(ctrl),
      .done(core_done),
      .det(core_det)
   );

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      status_in     = status_ff;
      ctrl.start    = 1'b0;
      ctrl.size     = rows;
      rsp_valid_in  = rsp_valid_ff & ~rsp_item.ready;
      rsp_det_in    = rsp_det_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (cfg_wr) begin
               load_count_in = '0;
            end else if (req_fire) begin
               if (is_last) begin
                  load_count_in = '0;
                  if (rows != cols) begin
                     status_in = STATUS_NOT_SQUARE;
                     state_in  = S_FINISH;
                  end else begin
                     status_in  = STATUS_OK;
                     ctrl.start = 1'b1;
                     state_in   = S_CALC;
                  end
               end else begin
                  load_count_in = load_count_ff + COUNT_W'(1);
               end
            end
         end
         S_CALC: begin
            if (core_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_det_in    = (status_ff == STATUS_NOT_SQUARE) ? '0 : core_det;
               state_in      = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_LOAD;
         load_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         row_count_ff    <= MAX_SZ;
         column_count_ff <= MAX_SZ;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (cfg_wr && paddr[2] == REG_ROW_COUNT) begin
            row_count_ff <= pwdata[SIZE_W-1:0];
         end
         if (cfg_wr && paddr[2] == REG_COLUMN_COUNT) begin
            column_count_ff <= pwdata[SIZE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rsp_det_ff    <= rsp_det_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      unique case (paddr[2])
         REG_ROW_COUNT:    prdata = CSR_DATA_W'(row_count_ff);
         REG_COLUMN_COUNT: prdata = CSR_DATA_W'(column_count_ff);
         default:          prdata = '0;
      endcase
   end

   assign pready               = 1'b1;
   assign req_item.ready       = (state_ff == S_LOAD);
   assign rsp_item.valid       = rsp_valid_ff;
   assign rsp_item.determinant = rsp_det_ff;
   assign rsp_item.status      = rsp_status_ff;

   `MDE_ASSERT(a_no_load_while_busy, (state_ff != S_LOAD) |-> !req_item.ready, "item taken while busy")
   `MDE_ASSERT(a_error_gives_zero, (rsp_item.valid && rsp_item.status) |-> (rsp_item.determinant == '0), "error item with non-zero determinant")
   `MDE_ASSERT(a_count_in_range, (state_ff == S_LOAD) |-> (load_count_ff < total), "load count past matrix size")
   `MDE_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_item.valid && state_ff == S_LOAD), "reset left item pending")

endmodule

### tb/sv/mde_checker.sv
// ------------------------------------------------------------------------
// mde_checker
// follows register writes and element items on the bus, works out the
// determinant each completed matrix should give, and compares it with
// every result item that the engine hands out
// ------------------------------------------------------------------------
module mde_checker (
   input  logic                               clock,
   input  logic                               reset,
   mde_req_if                                 req,
   mde_rsp_if                                 rsp,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic                               pready,
   input  logic [mde_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mde_pkg::CSR_DATA_W-1:0]     pwdata,
   output int                                 fail_count,
   output int                                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import mde_pkg::*;

   typedef struct {
      logic signed [DET_W-1:0] determinant;
      logic                    status;
   } det_result_type;

   det_result_type   det_queue[$];
   logic [SIZE_W-1:0] row_reg;
   logic [SIZE_W-1:0] col_reg;
   longint           matrix[16];
   int               loaded;

   function automatic int size_in_use(input logic [SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > 4) return 4;
      return int'(v);
   endfunction

   function automatic longint determinant_of(input longint m[16], input int n);
      longint minor[16];
      longint acc;
      int     k;
      acc = 0;
      if (n <= 1) return m[0];
      if (n == 2) return m[0] * m[3] - m[1] * m[2];
      for (int col = 0; col < n; col++) begin
         k = 0;
         for (int r = 1; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               if (c != col) begin
                  minor[k] = m[r * n + c];
                  k++;
               end
            end
         end
         if (col % 2 == 0) begin
            acc += m[col] * determinant_of(minor, n - 1);
         end else begin
            acc -= m[col] * determinant_of(minor, n - 1);
         end
      end
      return acc;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending_count = 0;
      loaded = 0;
      row_reg = 4;
      col_reg = 4;
      foreach (matrix[i]) matrix[i] = 0;
   end

   always @(posedge clock) begin
      det_result_type exp_item;
      int rows;
      int cols;
      if (reset) begin
         det_queue.delete();
         row_reg = 4;
         col_reg = 4;
         loaded = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == 3'(4 * REG_ROW_COUNT)) begin
               row_reg = pwdata[SIZE_W-1:0];
               loaded = 0;
            end else if (paddr == 3'(4 * REG_COLUMN_COUNT)) begin
               col_reg = pwdata[SIZE_W-1:0];
               loaded = 0;
            end
         end
         if (rsp.valid && rsp.ready) begin
            if (det_queue.size() == 0) begin
               report("result item with nothing expected", rsp.determinant, 0);
            end else begin
               exp_item = det_queue.pop_front();
               if (rsp.determinant !== exp_item.determinant)
                  report("determinant", rsp.determinant, exp_item.determinant);
               if (rsp.status !== exp_item.status)
                  report("status", rsp.status, exp_item.status);
            end
         end
         if (req.valid && req.ready) begin
            rows = size_in_use(row_reg);
            cols = size_in_use(col_reg);
            if (loaded < 16) matrix[loaded] = longint'(req.element_value);
            loaded++;
            if (loaded >= rows * cols) begin
               loaded = 0;
               if (rows != cols) begin
                  exp_item.determinant = '0;
                  exp_item.status = STATUS_NOT_SQUARE;
               end else begin
                  exp_item.determinant = DET_W'(determinant_of(matrix, rows));
                  exp_item.status = STATUS_OK;
               end
               det_queue.push_back(exp_item);
            end
         end
      end
      pending_count <= det_queue.size();
   end

endmodule

### tb/sv/tb_matrix_determinant_engine.sv
// ------------------------------------------------------------------------
// tb_matrix_determinant_engine
// drives size settings and matrix elements into the engine with random
// gaps on both channels; a checker beside the engine predicts each result
// ------------------------------------------------------------------------
module tb_matrix_determinant_engine;
   timeunit 1ns;
   timeprecision 1ps;
   import mde_pkg::*;

   localparam int SETTLE_CYCLES = 130;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    fail_count;
   int                    pending_count;
   int                    idle_cycles;
   int                    items_sent;
   bit                    burst_mode;

   mde_req_if req_item ();
   mde_rsp_if rsp_item ();

   matrix_determinant_engine u_top (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .rsp_item (rsp_item),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mde_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_item),
      .rsp           (rsp_item),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // no-progress watchdog
   always @(posedge clock) begin
      if (reset || (req_item.valid && req_item.ready) || (rsp_item.valid && rsp_item.ready)
          || (psel && penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("matrix_determinant_engine test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int gap_length();
      if (burst_mode) return 0;
      return $urandom_range(0, 12);
   endfunction

   function automatic logic signed [ELEM_W-1:0] random_element();
      case ($urandom_range(0, 7))
         0:       return -12'sd2048;
         1:       return 12'sd2047;
         2:       return 12'($urandom_range(0, 7)) - 12'sd3;
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [SIZE_W-1:0] v);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= CSR_DATA_W'($urandom) & ~CSR_DATA_W'(7) | CSR_DATA_W'(v);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_size(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] cols);
      csr_write(CSR_ADDR_W'(4 * REG_ROW_COUNT), rows);
      csr_write(CSR_ADDR_W'(4 * REG_COLUMN_COUNT), cols);
   endtask

   task automatic send_element(input logic signed [ELEM_W-1:0] v);
      int gap;
      gap = gap_length();
      repeat (gap) begin
         @(negedge clock);
         req_item.valid <= 1'b0;
      end
      @(negedge clock);
      req_item.valid <= 1'b1;
      req_item.element_value <= v;
      do @(posedge clock); while (!req_item.ready);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_item.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_matrices(input int count, input int elements);
      for (int i = 0; i < count; i++)
         for (int j = 0; j < elements; j++) send_element(random_element());
   endtask

   // result side stalls
   initial begin
      int stall;
      rsp_item.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = gap_length();
         repeat (stall) begin
            rsp_item.ready <= 1'b0;
            @(negedge clock);
         end
         rsp_item.ready <= 1'b1;
         do @(posedge clock); while (!rsp_item.valid);
         @(negedge clock);
      end
   end

   initial begin
      int rows;
      int cols;
      int n;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_item.valid = 1'b0;
      req_item.element_value = '0;
      idle_cycles = 0;
      items_sent = 0;
      burst_mode = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero sizes act as one by one
      set_size(0, 0);
      send_element(12'sd2047);
      send_element(-12'sd2048);
      wait_drained();
      set_size(2, 2);
      send_element(12'sd2047);
      send_element(-12'sd2048);
      send_element(-12'sd2048);
      send_element(12'sd2047);
      wait_drained();
      // not square
      set_size(1, 3);
      send_matrices(1, 3);
      wait_drained();
      // partial load dropped by a register write, sizes above four saturate
      set_size(7, 7);
      send_element(12'sd5);
      send_element(-12'sd1);
      wait_drained();
      set_size(3, 3);
      send_element(-12'sd2048);
      send_element(12'sd2047);
      send_element(12'sd0);
      send_element(12'sd2047);
      send_element(-12'sd2048);
      send_element(12'sd2047);
      send_element(12'sd1);
      send_element(-12'sd2048);
      send_element(-12'sd2048);
      wait_drained();

      while (items_sent < 1400) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 9) < 7) begin
            rows = $urandom_range(1, 4);
            cols = rows;
         end else begin
            rows = $urandom_range(0, 7);
            cols = $urandom_range(0, 7);
         end
         set_size(rows, cols);
         rows = (rows == 0) ? 1 : (rows > 4) ? 4 : rows;
         cols = (cols == 0) ? 1 : (cols > 4) ? 4 : cols;
         n = rows * cols;
         send_matrices($urandom_range(1, 6), n);
         if (n > 1 && $urandom_range(0, 5) == 0) send_matrices(1, $urandom_range(1, n - 1));
         wait_drained();
      end

      burst_mode = 1'b0;
      wait_drained();
      if (fail_count == 0 && pending_count == 0) begin
         $display("matrix_determinant_engine test passed");
      end else begin
         $display("matrix_determinant_engine test failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mde_pkg.sv
hw/rtl/mde_interfaces.sv
hw/rtl/mde_core.sv
hw/rtl/matrix_determinant_engine.sv
tb/sv/mde_checker.sv
tb/sv/tb_matrix_determinant_engine.sv
